### rtl/thmhp_pkg.sv
package thmhp_pkg;

    localparam int NAME_MAX_BYTES_DEFAULT = 128;

    localparam logic [7:0] CHR_T = 8'h54;
    localparam logic [7:0] CHR_H = 8'h48;
    localparam logic [7:0] CHR_X = 8'h58;
    localparam logic [7:0] CHR_V = 8'h56;
    localparam logic [7:0] CHR_L = 8'h4c;

    localparam logic [7:0] THX_VERSION_LIMIT = 8'd3;
    localparam logic [7:0] HVL_VERSION_LIMIT = 8'd2;

    localparam logic [7:0] TRACK_EMPTY_ENTRY = 8'h3f;

    localparam logic RESULT_NAME    = 1'b0;
    localparam logic RESULT_VERDICT = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] name_char;
        logic       accepted;
        logic       format_hvl;
        logic [6:0] channel_count;
        logic       run_end;
    } result_t;

endpackage

### rtl/thmhp_in_stage.sv
module thmhp_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  thmhp_pkg::item_t s_item,
    input  logic            out_free,
    output logic            step,
    output thmhp_pkg::item_t item
);

    logic             valid_reg;
    thmhp_pkg::item_t item_reg;

    assign step    = valid_reg && out_free;
    assign s_ready = !valid_reg || step;
    assign item    = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (step) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

### rtl/thmhp_core.sv
module thmhp_core #(
    parameter int NAME_MAX_BYTES = thmhp_pkg::NAME_MAX_BYTES_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  thmhp_pkg::item_t   item,
    output logic               res_valid,
    output thmhp_pkg::result_t res
);

    localparam int LEN_W = $clog2(NAME_MAX_BYTES + 1);
    localparam logic [LEN_W-1:0] NAME_LIMIT = LEN_W'(NAME_MAX_BYTES);

    localparam logic [4:0] HDR_FIRST  = 5'd4;
    localparam logic [4:0] HDR_POS_HI = 5'd6;
    localparam logic [4:0] HDR_POS_LO = 5'd7;
    localparam logic [4:0] HDR_CHAN   = 5'd8;
    localparam logic [4:0] HDR_TLEN   = 5'd10;
    localparam logic [4:0] HDR_TCNT   = 5'd11;
    localparam logic [4:0] HDR_ICNT   = 5'd12;
    localparam logic [4:0] HDR_SUBS   = 5'd13;
    localparam logic [4:0] HDR_END_HVL = 5'd15;
    localparam logic [4:0] INSTR_COUNT_BYTE = 5'd21;

    typedef enum logic [2:0] {
        PH_MAGIC, PH_HEADER, PH_SKIP, PH_TRACK, PH_INSTR, PH_ISKIP, PH_NAME, PH_DONE
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [4:0]       hidx_reg, hidx_next;
    logic             hvl_reg, hvl_next;
    logic             tzero_reg, tzero_next;
    logic [11:0]      pos_reg, pos_next;
    logic [6:0]       chan_reg, chan_next;
    logic [7:0]       tlen_reg, tlen_next;
    logic [8:0]       tcnt_reg, tcnt_next;
    logic [7:0]       row_reg, row_next;
    logic [7:0]       icnt_reg, icnt_next;
    logic [4:0]       ibyte_reg, ibyte_next;
    logic [19:0]      skip_reg, skip_next;
    logic [LEN_W-1:0] nlen_reg, nlen_next;
    logic             vsent_reg, vsent_next;
    logic [19:0]      pre_reg, pre_next;

    logic [11:0] mul_a;
    logic [9:0]  mul_b;
    logic [21:0] mul_p;
    logic [8:0]  tcnt_plus;
    logic [10:0] iskip_len;

    logic [7:0] b;
    logic       last;
    logic       ok, verdict, acc, named, restart;
    logic       go_skip, go_tracks, go_instr, go_name;
    logic       fmt;
    logic [6:0] chn;

    assign b    = item.data_byte;
    assign last = item.last_byte;

    // Skip length of the fixed-size areas, prepared one byte before it is needed.
    assign tcnt_plus = tcnt_reg + 9'(tzero_reg);
    assign mul_a     = hvl_reg ? pos_reg : {3'b000, tcnt_plus};
    assign mul_b     = hvl_reg ? {2'b00, chan_reg, 1'b0}
                               : ({2'b00, tlen_reg} + {1'b0, tlen_reg, 1'b0});
    assign mul_p     = mul_a * mul_b;
    assign pre_next  = mul_p[19:0] + (hvl_reg ? 20'd0 : {5'd0, pos_reg, 3'b000});
    assign iskip_len = {1'b0, b, 2'b00} + (hvl_reg ? {3'b000, b} : 11'd0);

    always_comb begin
        phase_next = phase_reg;
        hidx_next  = hidx_reg;
        hvl_next   = hvl_reg;
        tzero_next = tzero_reg;
        pos_next   = pos_reg;
        chan_next  = chan_reg;
        tlen_next  = tlen_reg;
        tcnt_next  = tcnt_reg;
        row_next   = row_reg;
        icnt_next  = icnt_reg;
        ibyte_next = ibyte_reg;
        skip_next  = skip_reg;
        nlen_next  = nlen_reg;
        vsent_next = vsent_reg;
        ok = 1'b0;
        verdict = 1'b0;
        acc = 1'b0;
        named = 1'b0;
        restart = 1'b0;
        go_skip = 1'b0;
        go_tracks = 1'b0;
        go_instr = 1'b0;
        go_name = 1'b0;
        fmt = 1'b0;
        chn = 7'd0;

        if (vsent_reg) begin
            restart = last;
        end else begin
            unique case (phase_reg)
                PH_MAGIC: begin
                    priority case (hidx_reg)
                        5'd0: begin
                            ok = (b == thmhp_pkg::CHR_T) || (b == thmhp_pkg::CHR_H);
                            hvl_next = (b == thmhp_pkg::CHR_H);
                        end
                        5'd1: ok = (b == (hvl_reg ? thmhp_pkg::CHR_V : thmhp_pkg::CHR_H));
                        5'd2: ok = (b == (hvl_reg ? thmhp_pkg::CHR_L : thmhp_pkg::CHR_X));
                        default: ok = (b < (hvl_reg ? thmhp_pkg::HVL_VERSION_LIMIT
                                                    : thmhp_pkg::THX_VERSION_LIMIT));
                    endcase
                    if (!ok) begin
                        verdict = 1'b1;
                    end else if (hidx_reg >= 5'd3) begin
                        phase_next = PH_HEADER;
                        hidx_next  = HDR_FIRST;
                    end else begin
                        hidx_next = hidx_reg + 5'd1;
                    end
                end
                PH_HEADER: begin
                    priority case (hidx_reg)
                        HDR_POS_HI: begin
                            tzero_next = !b[7];
                            pos_next   = {b[3:0], 8'd0};
                        end
                        HDR_POS_LO: pos_next = pos_reg | {4'd0, b};
                        HDR_CHAN: begin
                            if (hvl_reg) begin
                                chan_next = {1'b0, b[7:2]} + 7'd4;
                            end
                        end
                        HDR_TLEN: tlen_next = b;
                        HDR_TCNT: tcnt_next = {1'b0, b};
                        HDR_ICNT: icnt_next = b;
                        HDR_SUBS: skip_next = {11'd0, b, 1'b0} + pre_reg;
                        default: ;
                    endcase
                    if (hidx_reg >= (hvl_reg ? HDR_END_HVL : HDR_SUBS)) begin
                        tcnt_next = hvl_reg ? tcnt_plus : 9'd0;
                        go_skip = 1'b1;
                    end else begin
                        hidx_next = hidx_reg + 5'd1;
                    end
                end
                PH_SKIP: begin
                    skip_next = skip_reg - 20'd1;
                    go_tracks = (skip_next == 20'd0);
                end
                PH_TRACK: begin
                    if (skip_reg != 20'd0 || b != thmhp_pkg::TRACK_EMPTY_ENTRY) begin
                        if (skip_reg != 20'd0) begin
                            skip_next = skip_reg - 20'd1;
                        end else begin
                            skip_next = 20'd4;
                        end
                    end
                    // An entry ends on its last byte, or at once when it is a one-byte entry.
                    if ((skip_reg == 20'd1) ||
                        (skip_reg == 20'd0 && b == thmhp_pkg::TRACK_EMPTY_ENTRY)) begin
                        row_next = row_reg - 8'd1;
                        if (row_next == 8'd0) begin
                            tcnt_next = tcnt_reg - 9'd1;
                            if (tcnt_next == 9'd0) begin
                                go_instr = 1'b1;
                            end else begin
                                row_next = tlen_reg;
                            end
                        end
                    end
                end
                PH_INSTR: begin
                    if (ibyte_reg >= INSTR_COUNT_BYTE) begin
                        skip_next = {9'd0, iskip_len};
                        if (iskip_len != 11'd0) begin
                            phase_next = PH_ISKIP;
                        end else begin
                            icnt_next = icnt_reg - 8'd1;
                            if (icnt_next == 8'd0) begin
                                go_name = 1'b1;
                            end else begin
                                ibyte_next = 5'd0;
                            end
                        end
                    end else begin
                        ibyte_next = ibyte_reg + 5'd1;
                    end
                end
                PH_ISKIP: begin
                    skip_next = skip_reg - 20'd1;
                    if (skip_next == 20'd0) begin
                        icnt_next = icnt_reg - 8'd1;
                        if (icnt_next == 8'd0) begin
                            go_name = 1'b1;
                        end else begin
                            ibyte_next = 5'd0;
                        end
                    end
                end
                PH_NAME: begin
                    if (b == 8'd0) begin
                        verdict = 1'b1;
                        acc = 1'b1;
                    end else if (nlen_reg + LEN_W'(1) < NAME_LIMIT) begin
                        named = 1'b1;
                        nlen_next = nlen_reg + LEN_W'(1);
                    end
                end
                PH_DONE: ;
                default: ;
            endcase

            // Empty areas fall through to the next one within the same transaction.
            if (go_skip) begin
                if (skip_next == 20'd0) begin
                    go_tracks = 1'b1;
                end else begin
                    phase_next = PH_SKIP;
                end
            end
            if (go_tracks) begin
                if (hvl_next && tcnt_next != 9'd0 && tlen_next != 8'd0) begin
                    phase_next = PH_TRACK;
                    row_next   = tlen_next;
                    skip_next  = 20'd0;
                end else begin
                    go_instr = 1'b1;
                end
            end
            if (go_instr) begin
                if (icnt_next == 8'd0) begin
                    go_name = 1'b1;
                end else begin
                    phase_next = PH_INSTR;
                    ibyte_next = 5'd0;
                end
            end
            if (go_name) begin
                phase_next = PH_NAME;
                nlen_next  = '0;
            end

            if (!verdict && last) begin
                verdict = 1'b1;
                acc = 1'b0;
            end

            if (verdict) begin
                if (phase_next != PH_MAGIC) begin
                    fmt = hvl_next;
                    if (!hvl_next) begin
                        chn = 7'd4;
                    end else if (phase_next != PH_HEADER) begin
                        chn = chan_next;
                    end
                end
                if (last) begin
                    restart = 1'b1;
                end else begin
                    vsent_next = 1'b1;
                    phase_next = PH_DONE;
                end
            end
        end

        if (restart) begin
            phase_next = PH_MAGIC;
            hidx_next  = 5'd0;
            hvl_next   = 1'b0;
            tzero_next = 1'b0;
            pos_next   = 12'd0;
            chan_next  = 7'd4;
            tlen_next  = 8'd0;
            tcnt_next  = 9'd0;
            row_next   = 8'd0;
            icnt_next  = 8'd0;
            ibyte_next = 5'd0;
            skip_next  = 20'd0;
            nlen_next  = '0;
            vsent_next = 1'b0;
        end
    end

    assign res_valid         = verdict || named;
    assign res.result_kind   = verdict ? thmhp_pkg::RESULT_VERDICT : thmhp_pkg::RESULT_NAME;
    assign res.name_char     = verdict ? 8'd0 : b;
    assign res.accepted      = acc;
    assign res.format_hvl    = fmt;
    assign res.channel_count = chn;
    assign res.run_end       = verdict;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_MAGIC;
            hidx_reg  <= 5'd0;
            hvl_reg   <= 1'b0;
            tzero_reg <= 1'b0;
            pos_reg   <= 12'd0;
            chan_reg  <= 7'd4;
            tlen_reg  <= 8'd0;
            tcnt_reg  <= 9'd0;
            row_reg   <= 8'd0;
            icnt_reg  <= 8'd0;
            ibyte_reg <= 5'd0;
            skip_reg  <= 20'd0;
            nlen_reg  <= '0;
            vsent_reg <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            hidx_reg  <= hidx_next;
            hvl_reg   <= hvl_next;
            tzero_reg <= tzero_next;
            pos_reg   <= pos_next;
            chan_reg  <= chan_next;
            tlen_reg  <= tlen_next;
            tcnt_reg  <= tcnt_next;
            row_reg   <= row_next;
            icnt_reg  <= icnt_next;
            ibyte_reg <= ibyte_next;
            skip_reg  <= skip_next;
            nlen_reg  <= nlen_next;
            vsent_reg <= vsent_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && phase_reg == PH_HEADER && hidx_reg == HDR_ICNT) begin
            pre_reg <= pre_next;
        end
    end

    a_sent_means_done: assert property (@(posedge aclk) disable iff (!aresetn)
        vsent_reg |-> phase_reg == PH_DONE)
        else $error("verdict flag set outside the done phase");

    a_name_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        nlen_reg < NAME_LIMIT)
        else $error("name length reached its limit");

    a_track_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_TRACK |-> row_reg != 8'd0 && tcnt_reg != 9'd0)
        else $error("track walk with no rows left");

    a_instr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_INSTR || phase_reg == PH_ISKIP) |-> icnt_reg != 8'd0)
        else $error("instrument walk with no instruments left");

    a_verdict_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res_valid && res.run_end |=> vsent_reg || phase_reg == PH_MAGIC)
        else $error("parser still active after a verdict");

endmodule

### rtl/thmhp_out_stage.sv
module thmhp_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic               res_valid,
    input  thmhp_pkg::result_t res,
    output logic               out_free,
    output logic               m_valid,
    input  logic               m_ready,
    output thmhp_pkg::result_t m_res
);

    logic               valid_reg;
    thmhp_pkg::result_t res_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_res    = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (step) begin
            valid_reg <= res_valid;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            res_reg <= res;
        end
    end

endmodule

### rtl/tracker_module_header_parser_top.sv
// Throughput: one byte per cycle while m_ready does not hold back a pending result; each
// byte passes the input register, one step of the header state machine and the result register.
// Reset: aresetn is synchronous and active low; it empties both registers and puts
// the parser back to the magic check with all counters cleared.
module tracker_module_header_parser_top #(
    parameter int NAME_MAX_BYTES = thmhp_pkg::NAME_MAX_BYTES_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_result_kind,
    output logic [7:0] m_name_char,
    output logic       m_accepted,
    output logic       m_format_hvl,
    output logic [6:0] m_channel_count,
    output logic       m_run_end
);

    thmhp_pkg::item_t   s_item;
    thmhp_pkg::item_t   item;
    thmhp_pkg::result_t res;
    thmhp_pkg::result_t m_res;
    logic               step;
    logic               out_free;
    logic               res_valid;

    assign s_item.data_byte = s_data_byte;
    assign s_item.last_byte = s_last_byte;

    thmhp_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .out_free (out_free),
        .step     (step),
        .item     (item)
    );

    thmhp_core #(
        .NAME_MAX_BYTES (NAME_MAX_BYTES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    thmhp_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_result_kind   = m_res.result_kind;
    assign m_name_char     = m_res.name_char;
    assign m_accepted      = m_res.accepted;
    assign m_format_hvl    = m_res.format_hvl;
    assign m_channel_count = m_res.channel_count;
    assign m_run_end       = m_res.run_end;

endmodule
